[hdl/ttrc_pkg.sv]
`timescale 1ns / 1ps

package ttrc_pkg;

    localparam int unsigned DATA_W       = 8;
    localparam int unsigned TERM_W       = 16;
    localparam int unsigned ALPHA_STEP   = 17;
    localparam int unsigned BETA_STEP    = 31;
    localparam int unsigned FIRST_OFFSET = 7;
    localparam int unsigned CK_MOD       = 65535;
    // multiple of the modulus that lifts any difference above zero
    localparam int unsigned CK_BIAS      = CK_MOD * 257;

    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    // one classified word handed from the front to the back
    typedef struct packed {
        logic              first;
        logic              last;
        logic [DATA_W-1:0] data_byte;
        logic [7:0]        alpha;
        logic [7:0]        beta;
    } ttrc_cmd_t;

    // low byte of index times a small constant
    function automatic logic [7:0] step_coef(input logic [7:0] idx, input int unsigned k);
        logic [15:0] p;
        p = 16'(idx) * 16'(k);
        return p[7:0];
    endfunction

endpackage

[hdl/ttrc_front.sv]
`timescale 1ns / 1ps

module ttrc_front
    import ttrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              is_last,
    output ttrc_cmd_t         cmd
);

    logic       first_reg;
    logic       first_next;
    logic [7:0] index_reg;
    logic [7:0] index_next;

    // classify the word against the running stream position
    always_comb
    begin
        cmd.first     = first_reg;
        cmd.last      = is_last;
        cmd.data_byte = data_byte;
        cmd.alpha     = step_coef(index_reg, ALPHA_STEP);
        cmd.beta      = step_coef(index_reg, BETA_STEP);
    end

    always_comb
    begin
        first_next = first_reg;
        index_next = index_reg;
        if (accept)
        begin
            if (is_last)
            begin
                first_next = 1'b1;
                index_next = 8'd0;
            end
            else
            begin
                first_next = 1'b0;
                index_next = first_reg ? 8'd1 : index_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            index_reg <= 8'd0;
        end
        else
        begin
            first_reg <= first_next;
            index_reg <= index_next;
        end
    end

endmodule

[hdl/ttrc_queue.sv]
`timescale 1ns / 1ps

module ttrc_queue
    import ttrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ttrc_cmd_t push_cmd,
    output logic      not_full,
    input  logic      pop,
    output logic      not_empty,
    output ttrc_cmd_t pop_cmd
);

    ttrc_cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign not_full  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/ttrc_back.sv]
`timescale 1ns / 1ps

module ttrc_back
    import ttrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  ttrc_cmd_t         cmd,
    output logic              cmd_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TERM_W-1:0] out_data
);

    logic [TERM_W-1:0] older_reg;
    logic [TERM_W-1:0] older_next;
    logic [TERM_W-1:0] newer_reg;
    logic [TERM_W-1:0] newer_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TERM_W-1:0] out_data_reg;

    logic [8:0]        factor;
    logic [24:0]       prod;
    logic [23:0]       sub;
    logic              neg;
    logic [25:0]       lifted;
    logic [16:0]       folded;
    logic [TERM_W-1:0] step_term;
    logic [TERM_W-1:0] new_term;

    // recurrence: both products, signed difference, fold modulo 2^16-1
    always_comb
    begin
        factor    = 9'(cmd.data_byte) + 9'(cmd.alpha);
        prod      = 25'(factor) * 25'(newer_reg);
        sub       = 24'(cmd.beta) * 24'(older_reg);
        neg       = (prod < 25'(sub));
        lifted    = 26'(prod) + 26'(CK_BIAS) + 26'(neg) - 26'(sub);
        folded    = 17'(lifted[25:16]) + 17'(lifted[15:0]);
        step_term = (folded >= 17'(CK_MOD)) ? TERM_W'(folded - 17'(CK_MOD))
                                            : folded[TERM_W-1:0];
        new_term  = cmd.first ? TERM_W'(cmd.data_byte) + TERM_W'(FIRST_OFFSET)
                              : step_term;
    end

    // hold a stream's last word in the queue while a finished checksum still waits downstream
    assign cmd_pop = cmd_valid && (!cmd.last || !out_valid_reg || out_ready);

    always_comb
    begin
        older_next     = older_reg;
        newer_next     = newer_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd_pop)
        begin
            if (cmd.last)
            begin
                older_next     = TERM_W'(1);
                newer_next     = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                older_next = cmd.first ? TERM_W'(1) : newer_reg;
                newer_next = new_term;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg     <= TERM_W'(1);
            newer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            older_reg     <= older_next;
            newer_reg     <= newer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.last)
            out_data_reg <= new_term;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hdl/three_term_recurrence_checksum.sv]
`timescale 1ns / 1ps

// Three-term recurrence checksum. Bytes arrive one word per cycle on the
// s_axis side, tlast marking the final byte of a stream. The first byte seeds
// the newer term with byte+7 (older term 1); each later byte at position i
// forms ((byte + 17i mod 256) * newer - (31i mod 256) * older) mod 65535,
// a negative difference being taken as (1 + difference) mod 65535. On the
// last byte one 16-bit checksum word leaves on m_axis and the block rearms
// for the next stream. Throughput is one byte per cycle while the queue
// has room: the back-end recurrence loop is combinational between the term
// registers (two narrow multiplies, one subtract and one end-around fold).
// A front end tracks the stream position and derives both coefficients;
// a four-word queue separates it from the back end, so input keeps flowing
// while a checksum waits on m_axis. The last byte goes via a queue slot
// to the output register. No clearing pass or warm-up is needed after reset.

module three_term_recurrence_checksum
    import ttrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] checksum
);

    logic      in_accept;
    ttrc_cmd_t front_cmd;
    ttrc_cmd_t back_cmd;
    logic      q_valid;
    logic      q_pop;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // classify each word: stream start flag and position coefficients
    ttrc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (s_axis_tdata),
        .is_last   (s_axis_tlast),
        .cmd       (front_cmd)
    );

    // decouple front and back; stall input only when all slots are taken
    ttrc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_cmd  (front_cmd),
        .not_full  (s_axis_tready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (back_cmd)
    );

    // advance the recurrence and hold the checksum word in an output register
    ttrc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (back_cmd),
        .cmd_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // a finished stream never overwrites a checksum still waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && back_cmd.last) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("checksum word overwritten before it was taken");

    // the fold always yields a proper residue
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != 16'hFFFF))
        else $error("checksum outside residue range");

    // the back end only consumes words the queue actually holds
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ttrc_pkg::*;

    // Give up long after the slowest correct run could have ended.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned BACKLOG_HOLD = 300;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef enum int unsigned {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_BACKLOG
    } idle_phase_t;

    // One byte of a stream, together with its end-of-stream mark.
    typedef struct {
        logic [DATA_W-1:0] data_byte;
        logic              is_last;
    } stream_word_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] data_byte
    logic              s_axis_tlast;   // is_last
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // [15:0] checksum

    idle_phase_t       phase;
    stream_word_t      word_q[$];      // bytes waiting for the driver
    stream_word_t      next_word;
    logic [TERM_W-1:0] sum_q[$];       // checksums still owed by the block
    int unsigned       err_cnt;
    int unsigned       cycle_cnt;
    int unsigned       hold_left;
    bit                backlog_armed;

    // Our own copy of the recurrence state.
    logic [TERM_W-1:0] older_t;
    logic [TERM_W-1:0] newer_t;
    logic [7:0]        pos;
    bit                fresh;

    three_term_recurrence_checksum u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Rearm the recurrence for a new stream.
    task automatic rearm_terms();
        older_t = 16'd1;
        newer_t = '0;
        pos     = '0;
        fresh   = 1'b1;
    endtask

    // Advance the recurrence by one accepted byte; on the last byte owe a checksum.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [31:0]       alpha;
        logic [31:0]       beta;
        logic [31:0]       prod;
        logic [31:0]       sub;
        logic [31:0]       m;
        logic [TERM_W-1:0] nt;
        if (fresh)
        begin
            older_t = 16'd1;
            newer_t = TERM_W'(32'(b) + FIRST_OFFSET);
            pos     = 8'd1;
            fresh   = 1'b0;
        end
        else
        begin
            alpha = (32'(pos) * ALPHA_STEP) & 32'hFF;
            beta  = (32'(pos) * BETA_STEP) & 32'hFF;
            prod  = (32'(b) + alpha) * 32'(newer_t);
            sub   = beta * 32'(older_t);
            if (prod >= sub)
                nt = TERM_W'((prod - sub) % CK_MOD);
            else
            begin
                // Negative difference: reduce sub - prod - 1 and negate it to get (1 + diff) mod 65535.
                m  = (sub - prod - 32'd1) % CK_MOD;
                nt = (m != 0) ? TERM_W'(CK_MOD - m) : '0;
            end
            older_t = newer_t;
            newer_t = nt;
            pos     = pos + 8'd1;
        end
        if (last)
        begin
            sum_q.push_back(newer_t);
            rearm_terms();
        end
    endtask

    function automatic bit sender_rests();
        case (phase)
            PH_SEND_IDLE: return $urandom_range(99) < 63;
            PH_BOTH:      return $urandom_range(99) < 21;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (phase)
            PH_RECV_STALL: return $urandom_range(99) < 63;
            PH_BOTH:       return $urandom_range(99) < 21;
            default:       return 1'b0;
        endcase
    endfunction

    // Favor the extremes, otherwise any byte.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_word(input logic [7:0] b, input logic last);
        stream_word_t w;
        w.data_byte = b;
        w.is_last   = last;
        word_q.push_back(w);
    endtask

    task automatic push_stream(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            push_word(pick_byte(), k == len - 1);
    endtask

    // Queue random streams until about n_words bytes are pending.
    task automatic fill_streams(input int unsigned n_words, input int unsigned max_len);
        int unsigned done;
        int unsigned len;
        done = 0;
        while (done < n_words)
        begin
            if ($urandom_range(9) < 7)
                len = $urandom_range(8, 1);
            else
                len = $urandom_range(max_len, 1);
            push_stream(len);
            done += len;
        end
    endtask

    // Let the driver take everything queued, then move on at a falling edge.
    task automatic drain_words();
        wait (word_q.size() == 0);
        @(negedge clk);
    endtask

    // Driver: hold a word until it is accepted, then offer the next or go idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (word_q.size() != 0 && !sender_rests())
                begin
                    next_word = word_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.data_byte;
                    s_axis_tlast  <= next_word.is_last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once when the backlog phase begins.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left     <= 0;
            backlog_armed <= 1'b0;
        end
        else if (phase == PH_BACKLOG && !backlog_armed)
        begin
            hold_left     <= BACKLOG_HOLD;
            backlog_armed <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check every accepted checksum word against the oldest one owed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sum_q.size() == 0)
                begin
                    $error("checksum: unexpected word, actual %0d", m_axis_tdata);
                    err_cnt++;
                end
                else if (m_axis_tdata !== sum_q[0])
                begin
                    $error("checksum: expected %0d, actual %0d", sum_q[0], m_axis_tdata);
                    err_cnt++;
                    void'(sum_q.pop_front());
                end
                else
                    void'(sum_q.pop_front());
            end
            m_axis_tready <= !(hold_left != 0 || receiver_stalls());
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        err_cnt   = 0;
        cycle_cnt = 0;
        phase     = PH_FREE;
        rearm_terms();
        rst_n     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-byte streams at both extremes, flat and alternating
        // runs, and a mid-stream mix.
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b1);
        for (int k = 0; k < 4; k++)
            push_word(8'hFF, k == 3);
        for (int k = 0; k < 6; k++)
            push_word((k % 2) ? 8'hFF : 8'h00, k == 5);
        push_word(8'h80, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'hFE, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(8'h07, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        drain_words();

        // Random streams under each idling pattern; a few long ones wrap the
        // byte position past 255.
        phase = PH_FREE;
        push_stream(300);
        fill_streams(100, 40);
        drain_words();

        phase = PH_SEND_IDLE;
        fill_streams(350, 40);
        drain_words();

        phase = PH_RECV_STALL;
        fill_streams(350, 40);
        drain_words();

        phase = PH_BOTH;
        push_stream(270);
        fill_streams(100, 40);
        drain_words();

        // Short streams while the receiver holds off: results pile up and the
        // input side has to stall.
        phase = PH_BACKLOG;
        for (int k = 0; k < 120; k++)
            push_stream($urandom_range(2, 1));
        fill_streams(80, 12);
        drain_words();

        phase = PH_FREE;
        fill_streams(150, 20);
        drain_words();

        wait (!s_axis_tvalid);
        wait (sum_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && sum_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hdl/ttrc_pkg.sv
hdl/ttrc_front.sv
hdl/ttrc_queue.sv
hdl/ttrc_back.sv
hdl/three_term_recurrence_checksum.sv
tb/tb.sv
